[hw/rtl/u2l_pkg.sv]
package u2l_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxSeqLen = 4;
  localparam int unsigned PendDepth = 3;

  // A job holds a complete sequence or, at the end of a string, every
  // buffered byte. Entry 0 is the oldest byte.
  typedef struct packed {
    logic [MaxSeqLen-1:0][ByteW-1:0] bytes;
    logic [2:0]                      len;
    logic                            last;
  } job_t;

  // Sequence length that a lead byte announces.
  function automatic logic [2:0] seq_len(input logic [ByteW-1:0] b);
    logic [2:0] n;
    n = 3'd1;
    case (b) inside
      [8'h00:8'h7F]: n = 3'd1;
      [8'hC0:8'hDF]: n = 3'd2;
      [8'hE0:8'hEF]: n = 3'd3;
      [8'hF0:8'hF7]: n = 3'd4;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  // Low eight bits of the code point of a complete sequence of length n.
  // For any multibyte sequence these are the two low bits of the second to
  // last byte above the six low bits of the last byte.
  function automatic logic [ByteW-1:0] decode_low(
    input logic [MaxSeqLen-1:0][ByteW-1:0] s,
    input logic [2:0]                      n
  );
    logic [ByteW-1:0] r;
    r = s[0];
    case (n)
      3'd2:    r = {s[0][1:0], s[1][5:0]};
      3'd3:    r = {s[1][1:0], s[2][5:0]};
      3'd4:    r = {s[2][1:0], s[3][5:0]};
      default: r = s[0];
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/u2l_front.sv]
module u2l_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic          full_i,
  output logic          push_o,
  output u2l_pkg::job_t job_o
);
  import u2l_pkg::*;

  logic [PendDepth-1:0][ByteW-1:0] pend_q;
  logic [1:0]                      pcnt_q, pcnt_d;
  logic [MaxSeqLen-1:0][ByteW-1:0] buf_w;
  logic [2:0]                      len_w;
  logic                            complete_w;
  logic                            accept_w;

  assign in_ready_o = !full_i;
  assign accept_w   = in_valid_i && in_ready_o;

  // Buffered bytes followed by the new one.
  always_comb begin
    for (int k = 0; k < MaxSeqLen; k++) begin
      if (k < PendDepth && k < int'(pcnt_q)) begin
        buf_w[k] = pend_q[k];
      end else begin
        buf_w[k] = in_byte_i;
      end
    end
  end

  assign len_w      = {1'b0, pcnt_q} + 3'd1;
  assign complete_w = (len_w >= seq_len(buf_w[0]));

  assign push_o     = accept_w && (in_last_i || complete_w);
  assign job_o.bytes = buf_w;
  assign job_o.len   = len_w;
  assign job_o.last  = in_last_i;

  always_comb begin
    pcnt_d = pcnt_q;
    if (accept_w) begin
      if (!in_last_i && !complete_w) begin
        pcnt_d = pcnt_q + 2'd1;
      end else begin
        pcnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
    end else begin
      pcnt_q <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w && !in_last_i && !complete_w && pcnt_q < 2'(PendDepth)) begin
      pend_q[pcnt_q] <= in_byte_i;
    end
  end

endmodule

[hw/rtl/u2l_fifo.sv]
module u2l_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u2l_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output u2l_pkg::job_t data_o
);
  import u2l_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/u2l_back.sv]
module u2l_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  u2l_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);
  import u2l_pkg::*;

  logic [1:0]                      idx_q;
  logic [MaxSeqLen*ByteW-1:0]      win_flat;
  logic [MaxSeqLen-1:0][ByteW-1:0] win;
  logic [2:0]                      n_w, avail_w, step_w, next_w;
  logic                            multi_w, done_w, load_w;
  logic [ByteW-1:0]                res_w;
  logic                            valid_q;
  logic [ByteW-1:0]                byte_q;
  logic                            last_q;

  // Window that starts at the current position of the job.
  assign win_flat = job_i.bytes >> {idx_q, 3'b000};
  assign win      = win_flat;

  assign n_w     = seq_len(win[0]);
  assign avail_w = job_i.len - {1'b0, idx_q};
  assign multi_w = (n_w > 3'd1) && (n_w <= avail_w);
  assign step_w  = multi_w ? n_w : 3'd1;
  assign res_w   = multi_w ? decode_low(win, n_w) : win[0];
  assign next_w  = {1'b0, idx_q} + step_w;
  assign done_w  = (next_w >= job_i.len);

  assign load_w = !empty_i && (!valid_q || out_ready_i);
  assign pop_o  = load_w && done_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load_w) begin
        idx_q   <= done_w ? 2'd0 : next_w[1:0];
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      byte_q <= res_w;
      last_q <= job_i.last && done_w;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

[hw/rtl/utf8_to_latin1_decoder.sv]
// A result passes through the job queue and the registered output stage.
// Throughput: one input byte per cycle unless the job queue is full.
// A complete sequence gives one result; the back end emits one result per cycle from the
// job queue while the output is ready. At a string's end up to four buffered bytes flush.
// Reset (rst_ni, asynchronous, active low) clears the pending count, the queue and
// the output valid; buffered byte contents are left as they are.
module utf8_to_latin1_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import u2l_pkg::*;

  // The front end accepts one byte per transaction and collects the bytes of
  // a multibyte sequence. Once the sequence is complete, or the string ends,
  // it hands the collected bytes over as one job.
  logic push;
  logic full;
  job_t job_in;

  u2l_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  // The job queue lets the front end keep accepting bytes while the back end
  // works through a flush of several results.
  logic pop;
  logic empty;
  job_t job_head;

  u2l_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_head)
  );

  // The back end walks through the head job, decoding one sequence or passing
  // one byte through per cycle, while the output is ready, into a registered output stage.
  u2l_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

`ifndef SYNTHESIS
  // Every queued job carries between one and four bytes.
  a_job_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (job_head.len != 3'd0 && job_head.len <= 3'd4))
    else $error("queued job has an illegal length");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job queue overflow");

  // Retiring a mid-string job leaves a result that is not flagged last.
  a_mid_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !job_head.last |=> out_valid_o && !out_last_o)
    else $error("mid-string job produced a last result");

  // Retiring an end-of-string job leaves the final result of the string.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && job_head.last |=> out_valid_o && out_last_o)
    else $error("end-of-string job did not produce a last result");
`endif

endmodule
